// File: sv/hfn_pkg.sv
// ----------------------------------------------------------------------------
// hfn_pkg
// Request/response types and register indexes of the height field normal unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hfn_pkg;

	typedef struct packed {
		logic              kind;
		logic [6:0]        col;
		logic [6:0]        row;
		logic signed [15:0] height_value;
	} hfn_req_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               out_of_range;
	} hfn_rsp_t;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [2:0] REG_GRID_COLUMNS = 3'd0;
	localparam logic [2:0] REG_GRID_ROWS    = 3'd1;
	localparam logic [2:0] REG_SPACING_X    = 3'd2;
	localparam logic [2:0] REG_SPACING_Z    = 3'd3;
	localparam logic [2:0] REG_WINDING_CCW  = 3'd4;
	localparam logic [2:0] REG_HEIGHT_ON_Y  = 3'd5;
	localparam logic [2:0] REG_QUAD_MODE    = 3'd6;

endpackage

`default_nettype wire

// File: sv/height_field_normal_unit.sv
// ----------------------------------------------------------------------------
// height_field_normal_unit
// Height grid store with a sequenced unit-normal calculator.
// ----------------------------------------------------------------------------
// A load request writes one height sample. A query request is worked by one
// shared 32x32 multiplier and a bit-serial sqrt/divide under a sequencer:
// grid reads, a difference step, multiply steps, an orientation step,
// normalize shifts, square steps, square-root steps and one divide pass per
// component, then the response is posted. An out-of-range query goes
// straight to posting its response. in_stall is high while a query is being
// worked; the response register lets the next request in while a response
// is still held.
`default_nettype none

module height_field_normal_unit
	import hfn_pkg::*;
#(
	parameter int MAX_COLUMNS      = 128,
	parameter int MAX_ROWS         = 128,
	parameter int HEIGHT_BITS      = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire hfn_req_t in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output hfn_rsp_t      out_data,
	input  wire logic     cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int IW   = 11;
	localparam int CAW  = $clog2(MAX_COLUMNS);
	localparam int RAW  = $clog2(MAX_ROWS);
	localparam int AW   = CAW + RAW;
	localparam int DFW  = HEIGHT_BITS + 2;
	localparam int MW   = HEIGHT_BITS + 28;
	localparam int SW   = 63;
	localparam int QW   = NORMAL_FRAC_BITS + 2;
	localparam int DW   = NORMAL_FRAC_BITS + 32;
	localparam int CNTW = 6;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_READ   = 4'd1;
	localparam logic [3:0] ST_DIFF   = 4'd2;
	localparam logic [3:0] ST_MUL    = 4'd3;
	localparam logic [3:0] ST_ORIENT = 4'd4;
	localparam logic [3:0] ST_NORM   = 4'd5;
	localparam logic [3:0] ST_SQ     = 4'd6;
	localparam logic [3:0] ST_SQRT   = 4'd7;
	localparam logic [3:0] ST_DIV    = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	// configuration
	logic [7:0]  grid_columns_q, grid_rows_q;
	logic [15:0] spacing_x_q, spacing_z_q;
	logic        winding_ccw_q, height_on_y_q, quad_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= 8'd2;
			grid_rows_q    <= 8'd2;
			spacing_x_q    <= 16'd256;
			spacing_z_q    <= 16'd256;
			winding_ccw_q  <= 1'b1;
			height_on_y_q  <= 1'b1;
			quad_mode_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_COLUMNS: grid_columns_q <= cfg_data[7:0];
				REG_GRID_ROWS:    grid_rows_q    <= cfg_data[7:0];
				REG_SPACING_X:    spacing_x_q    <= cfg_data;
				REG_SPACING_Z:    spacing_z_q    <= cfg_data;
				REG_WINDING_CCW:  winding_ccw_q  <= cfg_data[0];
				REG_HEIGHT_ON_Y:  height_on_y_q  <= cfg_data[0];
				REG_QUAD_MODE:    quad_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [IW-1:0] cols, rows, gc_w, gr_w;
	logic [15:0]   xs, zs;

	assign gc_w = IW'(grid_columns_q);
	assign gr_w = IW'(grid_rows_q);
	assign cols = (gc_w < IW'(2)) ? IW'(2) :
		((gc_w > IW'(MAX_COLUMNS)) ? IW'(MAX_COLUMNS) : gc_w);
	assign rows = (gr_w < IW'(2)) ? IW'(2) :
		((gr_w > IW'(MAX_ROWS)) ? IW'(MAX_ROWS) : gr_w);
	assign xs = (spacing_x_q == 16'd0) ? 16'd1 : spacing_x_q;
	assign zs = (spacing_z_q == 16'd0) ? 16'd1 : spacing_z_q;

	// sequencer state
	logic [3:0]      state_q;
	logic [CNTW-1:0] cnt_q;
	logic [1:0]      dsel_q;
	logic            oor_q;
	logic            out_valid_q;
	hfn_rsp_t        out_data_q;

	logic [IW-1:0] c_q, r_q;
	logic signed [HEIGHT_BITS-1:0] h_q [4];
	logic [DFW-1:0] adx_q, adz_q;
	logic           dbl_x_q, dbl_z_q;
	logic [MW-1:0]  mag_q [3];
	logic           sg_q [3];
	logic [63:0]    prod_q;
	logic [SW-1:0]  sqrem_q, sqres_q, sqbit_q;
	logic [DW-1:0]  drem_q, ddiv_q;
	logic [QW-1:0]  dq_q;
	logic [QW-1:0]  qres_q [3];

	// height store
	logic signed [HEIGHT_BITS-1:0] mem [2**AW];
	logic signed [HEIGHT_BITS-1:0] rdata_q;
	logic [IW-1:0] in_col_w, in_row_w;
	logic          mem_we;
	logic [AW-1:0] waddr, raddr;
	logic [IW-1:0] xa, za;

	assign in_col_w = IW'(in_data.col);
	assign in_row_w = IW'(in_data.row);
	assign in_stall = (state_q != ST_IDLE);
	assign mem_we = in_valid && !in_stall && (in_data.kind == KIND_LOAD) &&
		(in_col_w < IW'(MAX_COLUMNS)) && (in_row_w < IW'(MAX_ROWS));
	assign waddr = {in_row_w[RAW-1:0], in_col_w[CAW-1:0]};

	always_comb begin
		xa = c_q;
		za = r_q;
		if (quad_mode_q) begin
			unique case (cnt_q[1:0])
				2'd0: begin xa = c_q;         za = r_q;         end
				2'd1: begin xa = c_q + 1'b1;  za = r_q;         end
				2'd2: begin xa = c_q + 1'b1;  za = r_q + 1'b1;  end
				default: begin xa = c_q;      za = r_q + 1'b1;  end
			endcase
		end else begin
			unique case (cnt_q[1:0])
				2'd0: xa = (c_q == cols - 1'b1) ? c_q : c_q + 1'b1;
				2'd1: xa = (c_q == '0) ? c_q : c_q - 1'b1;
				2'd2: za = (r_q == rows - 1'b1) ? r_q : r_q + 1'b1;
				default: za = (r_q == '0) ? r_q : r_q - 1'b1;
			endcase
		end
	end

	assign raddr = {za[RAW-1:0], xa[CAW-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= HEIGHT_BITS'(in_data.height_value);
		rdata_q <= mem[raddr];
	end

	// differences
	logic signed [DFW-1:0] h0, h1, h2, h3, dxv, dzv;
	logic edge_x, edge_z;

	assign h0 = DFW'(h_q[0]);
	assign h1 = DFW'(h_q[1]);
	assign h2 = DFW'(h_q[2]);
	assign h3 = DFW'(h_q[3]);
	assign dxv = quad_mode_q ? (h0 - h1 - h2 + h3) : (h0 - h1);
	assign dzv = quad_mode_q ? (h0 + h1 - h2 - h3) : (h2 - h3);
	assign edge_x = !quad_mode_q && ((c_q == '0) || (c_q == cols - 1'b1));
	assign edge_z = !quad_mode_q && ((r_q == '0) || (r_q == rows - 1'b1));

	// shared multiplier
	logic [31:0] mul_a, mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_MUL) begin
			unique case (cnt_q[1:0])
				2'd0: begin mul_a = 32'(adx_q); mul_b = 32'(zs); end
				2'd1: begin mul_a = 32'(adz_q); mul_b = 32'(xs); end
				default: begin mul_a = 32'(xs); mul_b = 32'(zs); end
			endcase
		end else if (cnt_q[1:0] != 2'd3) begin
			mul_a = 32'(mag_q[cnt_q[1:0]]);
			mul_b = 32'(mag_q[cnt_q[1:0]]);
		end
	end

	always_ff @(posedge clk)
		prod_q <= mul_a * mul_b;

	// sqrt step
	logic [63:0] sq_trial;
	assign sq_trial = 64'(sqres_q) + 64'(sqbit_q);

	// divide step
	logic [QW-1:0] dq_next;
	logic          dge;
	assign dge = (drem_q >= ddiv_q);
	assign dq_next = {dq_q[QW-2:0], dge};

	logic [30:0] len;
	assign len = sqres_q[30:0];

	logic norm_hi, norm_lo;
	assign norm_hi = (|mag_q[0][MW-1:30]) || (|mag_q[1][MW-1:30]) || (|mag_q[2][MW-1:30]);
	assign norm_lo = !(mag_q[0][29] || mag_q[1][29] || mag_q[2][29]);

	logic w_flip;
	assign w_flip = !winding_ccw_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				c_q <= in_col_w;
				r_q <= in_row_w;
			end
			ST_READ: begin
				if (cnt_q != '0)
					h_q[cnt_q[1:0] - 2'd1] <= rdata_q;
			end
			ST_DIFF: begin
				adx_q   <= dxv[DFW-1] ? DFW'(-dxv) : DFW'(dxv);
				adz_q   <= dzv[DFW-1] ? DFW'(-dzv) : DFW'(dzv);
				sg_q[0] <= quad_mode_q ? dxv[DFW-1] : (dxv > 0);
				sg_q[2] <= quad_mode_q ? dzv[DFW-1] : (dzv > 0);
				sg_q[1] <= 1'b0;
				dbl_x_q <= edge_x;
				dbl_z_q <= edge_z;
			end
			ST_MUL: begin
				unique case (cnt_q[1:0])
					2'd1: mag_q[0] <= MW'(prod_q) << (dbl_x_q ? 9 : 8);
					2'd2: mag_q[2] <= MW'(prod_q) << (dbl_z_q ? 9 : 8);
					2'd3: mag_q[1] <= MW'(prod_q) << 1;
					default: ;
				endcase
			end
			ST_ORIENT: begin
				if (height_on_y_q) begin
					sg_q[0] <= sg_q[0] ^ w_flip;
					sg_q[1] <= sg_q[1] ^ w_flip;
					sg_q[2] <= sg_q[2] ^ w_flip;
				end else begin
					sg_q[0]  <= !(sg_q[0] ^ w_flip);
					sg_q[1]  <= !(sg_q[2] ^ w_flip);
					sg_q[2]  <= !(sg_q[1] ^ w_flip);
					mag_q[1] <= mag_q[2];
					mag_q[2] <= mag_q[1];
				end
			end
			ST_NORM: begin
				sqrem_q <= '0;
				if (norm_hi) begin
					mag_q[0] <= mag_q[0] >> 1;
					mag_q[1] <= mag_q[1] >> 1;
					mag_q[2] <= mag_q[2] >> 1;
				end else if (norm_lo) begin
					mag_q[0] <= mag_q[0] << 1;
					mag_q[1] <= mag_q[1] << 1;
					mag_q[2] <= mag_q[2] << 1;
				end
			end
			ST_SQ: begin
				if (cnt_q != '0)
					sqrem_q <= sqrem_q + SW'(prod_q);
				sqres_q <= '0;
				sqbit_q <= SW'(1) << 62;
			end
			ST_SQRT: begin
				if (64'(sqrem_q) >= sq_trial) begin
					sqrem_q <= sqrem_q - SW'(sq_trial);
					sqres_q <= (sqres_q >> 1) + sqbit_q;
				end else begin
					sqres_q <= sqres_q >> 1;
				end
				sqbit_q <= sqbit_q >> 2;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					drem_q <= (DW'(mag_q[dsel_q]) << NORMAL_FRAC_BITS) + DW'(len >> 1);
					ddiv_q <= DW'(len) << (QW - 1);
					dq_q   <= '0;
				end else begin
					if (dge)
						drem_q <= drem_q - ddiv_q;
					ddiv_q <= ddiv_q >> 1;
					dq_q   <= dq_next;
					if (cnt_q == CNTW'(QW))
						qres_q[dsel_q] <= dq_next;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			dsel_q  <= '0;
			oor_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					dsel_q <= '0;
					if (in_valid && in_data.kind == KIND_QUERY) begin
						if (quad_mode_q ? (in_col_w >= cols - 1'b1 || in_row_w >= rows - 1'b1)
						                : (in_col_w >= cols || in_row_w >= rows)) begin
							oor_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							oor_q   <= 1'b0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (cnt_q == CNTW'(4)) begin
						cnt_q   <= '0;
						state_q <= ST_DIFF;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL: begin
					if (cnt_q == CNTW'(3)) begin
						cnt_q   <= '0;
						state_q <= ST_ORIENT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ORIENT: state_q <= ST_NORM;
				ST_NORM: begin
					if (!norm_hi && !norm_lo)
						state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (cnt_q == CNTW'(3)) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == CNTW'(31)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNTW'(QW)) begin
						cnt_q <= '0;
						if (dsel_q == 2'd2)
							state_q <= ST_DONE;
						else
							dsel_q <= dsel_q + 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// response register
	logic [31:0] n0, n1, n2;
	assign n0 = sg_q[0] ? -32'(qres_q[0]) : 32'(qres_q[0]);
	assign n1 = sg_q[1] ? -32'(qres_q[1]) : 32'(qres_q[1]);
	assign n2 = sg_q[2] ? -32'(qres_q[2]) : 32'(qres_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_DONE && !out_valid_q)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !out_valid_q) begin
			out_data_q.normal_x     <= oor_q ? 16'sd0 : n0[15:0];
			out_data_q.normal_y     <= oor_q ? 16'sd0 : n1[15:0];
			out_data_q.normal_z     <= oor_q ? 16'sd0 : n2[15:0];
			out_data_q.out_of_range <= oor_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// File: test/height_field_normal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_field_normal_checker
// Watches the request and response channels of the height field normal unit,
// keeps its own copy of the grid and registers, predicts each normal and
// compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
module height_field_normal_checker
	import hfn_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire hfn_req_t    in_data,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire hfn_rsp_t    out_data,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               fail_count,
	output int               pending
);

	logic signed [15:0] grid [0:16383];
	logic [7:0]  cols_r, rows_r;
	logic [15:0] sx_r, sz_r;
	logic        ccw_r, hy_r, quad_r;
	hfn_rsp_t    normals_due [$];

	function automatic longint hts(int c, int r);
		if (c > 127 || r > 127)
			return 0;
		return longint'(grid[r * 128 + c]);
	endfunction

	function automatic longint unsigned root64(longint unsigned s);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic hfn_rsp_t surface_normal(int c, int r);
		hfn_rsp_t o;
		int cols, rows, i;
		longint xs, zs, t;
		longint v [3];
		longint unsigned mag [3];
		longint unsigned m, s, l, q;
		o = '0;
		cols = cols_r < 2 ? 2 : (cols_r > 128 ? 128 : cols_r);
		rows = rows_r < 2 ? 2 : (rows_r > 128 ? 128 : rows_r);
		xs = sx_r == 0 ? 1 : sx_r;
		zs = sz_r == 0 ? 1 : sz_r;
		if (quad_r ? (c + 1 >= cols || r + 1 >= rows) : (c >= cols || r >= rows)) begin
			o.out_of_range = 1'b1;
			return o;
		end
		if (quad_r) begin
			v[0] = (hts(c, r) - hts(c + 1, r) - hts(c + 1, r + 1) + hts(c, r + 1)) * zs * 256;
			v[2] = (hts(c, r) + hts(c + 1, r) - hts(c + 1, r + 1) - hts(c, r + 1)) * xs * 256;
		end else begin
			if (c == 0)
				v[0] = -(hts(c + 1, r) - hts(c, r)) * zs * 512;
			else if (c == cols - 1)
				v[0] = -(hts(c, r) - hts(c - 1, r)) * zs * 512;
			else
				v[0] = -(hts(c + 1, r) - hts(c - 1, r)) * zs * 256;
			if (r == 0)
				v[2] = -(hts(c, r + 1) - hts(c, r)) * xs * 512;
			else if (r == rows - 1)
				v[2] = -(hts(c, r) - hts(c, r - 1)) * xs * 512;
			else
				v[2] = -(hts(c, r + 1) - hts(c, r - 1)) * xs * 256;
		end
		v[1] = 2 * xs * zs;
		if (!ccw_r)
			for (i = 0; i < 3; i++) v[i] = -v[i];
		if (!hy_r) begin
			t = v[1];
			v[1] = v[2];
			v[2] = t;
			for (i = 0; i < 3; i++) v[i] = -v[i];
		end
		m = 0;
		for (i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? -v[i] : v[i];
			if (mag[i] > m) m = mag[i];
		end
		while (m >= (64'd1 << 30)) begin
			for (i = 0; i < 3; i++) mag[i] >>= 1;
			m >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			for (i = 0; i < 3; i++) mag[i] <<= 1;
			m <<= 1;
		end
		s = 0;
		for (i = 0; i < 3; i++) s += mag[i] * mag[i];
		l = root64(s);
		for (i = 0; i < 3; i++) begin
			q = ((mag[i] << 14) + (l >> 1)) / l;
			t = v[i] < 0 ? -longint'(q) : longint'(q);
			if (i == 0) o.normal_x = t[15:0];
			else if (i == 1) o.normal_y = t[15:0];
			else o.normal_z = t[15:0];
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hfn_rsp_t e;
		if (!arst_n) begin
			cols_r = 8'd2; rows_r = 8'd2; sx_r = 16'd256; sz_r = 16'd256;
			ccw_r = 1'b1; hy_r = 1'b1; quad_r = 1'b0;
			fail_count = 0;
			normals_due.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_COLUMNS: cols_r = cfg_data[7:0];
					REG_GRID_ROWS:    rows_r = cfg_data[7:0];
					REG_SPACING_X:    sx_r = cfg_data;
					REG_SPACING_Z:    sz_r = cfg_data;
					REG_WINDING_CCW:  ccw_r = cfg_data[0];
					REG_HEIGHT_ON_Y:  hy_r = cfg_data[0];
					REG_QUAD_MODE:    quad_r = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (normals_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected response %p", out_data);
				end else begin
					e = normals_due.pop_front();
					if (e !== out_data) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p actual %p", e, out_data);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.kind == KIND_LOAD)
					grid[in_data.row * 128 + in_data.col] = in_data.height_value;
				else
					normals_due.push_back(surface_normal(int'(in_data.col),
						int'(in_data.row)));
			end
			pending = normals_due.size();
		end
	end

endmodule

// File: test/height_field_normal_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_field_normal_unit_tb
// Loads height grids under several register settings, then issues directed
// and random normal queries with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module height_field_normal_unit_tb;
	import hfn_pkg::*;

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	hfn_req_t    in_data;
	hfn_rsp_t    out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count, pending;
	int          cycles;
	int          hold_requests;
	logic        quiet_rx;
	int          gcols, grows;

	height_field_normal_unit dut (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data
	);

	height_field_normal_checker chk (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data,
		.fail_count, .pending
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 900000) begin
				$display("[height_field_normal_unit] ERROR");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 93) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// receiver stalls
	initial begin
		int n, left, seen;
		out_stall = 1'b0;
		left = 0;
		seen = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != seen) begin
				seen = hold_requests;
				left = 600;
			end
			if (left > 0) begin
				out_stall = 1'b1;
				left--;
			end else if (quiet_rx) begin
				out_stall = 1'b0;
			end else begin
				n = gap_len();
				out_stall = n > 0;
				repeat (n > 0 ? n - 1 : 0) @(negedge clk);
			end
		end
	end

	task automatic send_request(logic k, int c, int r, logic signed [15:0] h);
		int g;
		g = gap_len();
		repeat (g) @(negedge clk);
		in_valid = 1'b1;
		in_data.kind = k;
		in_data.col = c[6:0];
		in_data.row = r[6:0];
		in_data.height_value = h;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
		in_data = hfn_req_t'($urandom);
	endtask

	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
		repeat (160) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_grid(int c, int r, logic [15:0] sx, logic [15:0] sz, logic ccw,
			logic hy, logic q);
		write_reg(REG_GRID_COLUMNS, c[15:0]);
		write_reg(REG_GRID_ROWS, r[15:0]);
		write_reg(REG_SPACING_X, sx);
		write_reg(REG_SPACING_Z, sz);
		write_reg(REG_WINDING_CCW, {15'd0, ccw});
		write_reg(REG_HEIGHT_ON_Y, {15'd0, hy});
		write_reg(REG_QUAD_MODE, {15'd0, q});
		gcols = c < 2 ? 2 : (c > 128 ? 128 : c);
		grows = r < 2 ? 2 : (r > 128 ? 128 : r);
	endtask

	function automatic logic signed [15:0] rand_height();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 20) - 10);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_queries(int n);
		int c, r, i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				// loads beyond the grid in use stay in the store, harmless
				send_request(KIND_LOAD, $urandom_range(0, 127), $urandom_range(0, 127),
					rand_height());
			end else if ($urandom_range(0, 9) == 0) begin
				c = $urandom_range(0, 127);
				r = $urandom_range(0, 127);
				if (c < gcols && r < grows)
					send_request(KIND_QUERY, c, r, 16'($urandom));
				else
					send_request(KIND_QUERY, c, r, 16'($urandom));
			end else begin
				c = $urandom_range(0, gcols - 1);
				r = $urandom_range(0, grows - 1);
				send_request(KIND_QUERY, c, r, 16'($urandom));
			end
		end
	endtask

	task automatic fill_grid(bit smooth);
		int c, r;
		for (r = 0; r < grows; r++)
			for (c = 0; c < gcols; c++)
				send_request(KIND_LOAD, c, r, smooth ? 16'(c * 3 - r * 5) : rand_height());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_COLUMNS;
		cfg_data = '0;
		quiet_rx = 1'b0;
		hold_requests = 0;
		gcols = 2; grows = 2;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset grid 2x2, full-scale corners
		send_request(KIND_LOAD, 0, 0, 16'sh7fff);
		send_request(KIND_LOAD, 1, 0, 16'sh8000);
		send_request(KIND_LOAD, 0, 1, 16'sh8000);
		send_request(KIND_LOAD, 1, 1, 16'sh7fff);
		send_request(KIND_QUERY, 0, 0, '0);
		send_request(KIND_QUERY, 1, 1, '0);
		send_request(KIND_QUERY, 2, 0, '0);
		send_request(KIND_QUERY, 127, 127, '0);
		send_request(KIND_LOAD, 127, 127, 16'sh1234);
		wait_drained();

		// quad, clockwise, Z height, extreme spacings, out-of-range dims saturate
		set_grid(0, 255, 16'hffff, 16'h0000, 0, 0, 1);
		send_request(KIND_QUERY, 0, 0, '0);
		send_request(KIND_QUERY, 1, 0, '0);
		send_request(KIND_QUERY, 0, 127, '0);
		wait_drained();
		set_grid(2, 2, 16'h0001, 16'hffff, 1, 0, 1);
		send_request(KIND_QUERY, 0, 0, '0);
		send_request(KIND_QUERY, 0, 1, '0);
		wait_drained();
		set_grid(2, 2, 16'h0100, 16'h0100, 0, 1, 0);
		send_request(KIND_QUERY, 0, 1, '0);
		send_request(KIND_QUERY, 1, 0, '0);
		wait_drained();

		// long receiver hold-off fills the block
		set_grid(8, 6, 16'h0180, 16'h0040, 1, 1, 0);
		fill_grid(1);
		wait_drained();
		hold_requests++;
		random_queries(40);
		wait_drained();

		set_grid(128, 2, 16'h0100, 16'h0100, 1, 1, 0);
		fill_grid(0);
		random_queries(200);
		wait_drained();

		repeat (4) begin
			set_grid($urandom_range(2, 16), $urandom_range(2, 16), 16'($urandom),
				16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
			fill_grid($urandom_range(0, 1));
			random_queries(110);
			wait_drained();
		end

		quiet_rx = 1'b1;
		set_grid(3, 3, 16'h0001, 16'h0001, 1, 1, 1);
		random_queries(40);
		wait_drained();

		if (fail_count == 0)
			$display("[height_field_normal_unit] OK");
		else
			$display("[height_field_normal_unit] ERROR");
		$finish;
	end

endmodule
